>>> design/tiny_accumulator_cpu_step_macros.svh
// Assertion macros shared by the accumulator machine RTL.
`ifndef TINY_ACCUMULATOR_CPU_STEP_MACROS_SVH
`define TINY_ACCUMULATOR_CPU_STEP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TACS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TACS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> design/tacs_pkg.sv
// Types and constants of the accumulator machine.
package tacs_pkg;

    localparam int MEM_WORDS = 16;
    localparam int ADDR_W    = $clog2(MEM_WORDS);
    localparam int DATA_W    = 8;
    localparam int OPC_W     = 3;
    localparam int CMD_W     = 2;
    localparam int MODE_POS  = 4;
    localparam int OPC_LSB   = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_EXEC    = 2'd1,
        CMD_READ    = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    typedef enum logic [OPC_W-1:0] {
        OP_LDA  = 3'd0,
        OP_STA  = 3'd1,
        OP_ADD  = 3'd2,
        OP_BRA  = 3'd3,
        OP_BEQ  = 3'd4,
        OP_SUB  = 3'd5,
        OP_NOP  = 3'd6,
        OP_STOP = 3'd7
    } t_opcode;

    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0] pc;
        logic [DATA_W-1:0] acc;
        logic              halt;
    } t_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_wr;

    typedef struct packed {
        logic [OPC_W-1:0]  executed_opcode;
        logic              halted;
        logic [DATA_W-1:0] accumulator;
        logic [ADDR_W-1:0] program_counter;
        logic [DATA_W-1:0] read_data;
    } t_result;

endpackage

>>> design/tacs_regfile.sv
// Main memory: 16 words in flip-flops, one write port, three read ports.
module tacs_regfile (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tacs_pkg::t_wr                 i_wr,
    input  logic [tacs_pkg::ADDR_W-1:0]   i_fetch_addr,
    input  logic [tacs_pkg::ADDR_W-1:0]   i_operand_addr,
    input  logic [tacs_pkg::ADDR_W-1:0]   i_read_addr,
    output logic [tacs_pkg::DATA_W-1:0]   o_fetch_word,
    output logic [tacs_pkg::DATA_W-1:0]   o_operand_word,
    output logic [tacs_pkg::DATA_W-1:0]   o_read_word
);
    import tacs_pkg::*;

    logic [DATA_W-1:0] r_mem [MEM_WORDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_WORDS; i++) begin
                r_mem[i] <= '0;
            end
        end else if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_fetch_word   = r_mem[i_fetch_addr];
    assign o_operand_word = r_mem[i_operand_addr];
    assign o_read_word    = r_mem[i_read_addr];

endmodule

>>> design/tacs_exec.sv
// Execute logic: decodes one command word and forms next state, write and result.
module tacs_exec (
    input  tacs_pkg::t_item               i_item,
    input  tacs_pkg::t_state              i_state,
    input  logic [tacs_pkg::DATA_W-1:0]   i_fetch_word,
    input  logic [tacs_pkg::DATA_W-1:0]   i_operand_word,
    input  logic [tacs_pkg::DATA_W-1:0]   i_read_word,
    output logic [tacs_pkg::ADDR_W-1:0]   o_operand_addr,
    output tacs_pkg::t_state              o_next,
    output tacs_pkg::t_wr                 o_wr,
    output tacs_pkg::t_result             o_result
);
    import tacs_pkg::*;

    t_opcode           opcode;
    logic [ADDR_W-1:0] operand;
    logic [DATA_W-1:0] source;
    logic [DATA_W-1:0] read_value;
    logic [OPC_W-1:0]  done_opcode;

    assign opcode         = t_opcode'(i_fetch_word[OPC_LSB +: OPC_W]);
    assign operand        = i_fetch_word[ADDR_W-1:0];
    assign o_operand_addr = operand;
    // Immediate mode takes the operand itself, absolute mode the word it points to.
    assign source = i_fetch_word[MODE_POS] ? {{(DATA_W-ADDR_W){1'b0}}, operand}
                                           : i_operand_word;

    always_comb begin
        o_next      = i_state;
        o_wr        = '0;
        read_value  = '0;
        done_opcode = '0;
        unique case (i_item.cmd)
            CMD_LOAD: begin
                o_wr.en   = 1'b1;
                o_wr.addr = i_item.address;
                o_wr.data = i_item.write_data;
            end
            CMD_EXEC: begin
                if (!i_state.halt) begin
                    o_next.pc   = i_state.pc + ADDR_W'(1);
                    done_opcode = opcode;
                    unique case (opcode)
                        OP_LDA:  o_next.acc = source;
                        OP_STA: begin
                            o_wr.en   = 1'b1;
                            o_wr.addr = operand;
                            o_wr.data = i_state.acc;
                        end
                        OP_ADD:  o_next.acc = i_state.acc + source;
                        OP_BRA:  o_next.pc  = operand;
                        OP_BEQ: begin
                            if (i_state.acc == '0) begin
                                o_next.pc = operand;
                            end
                        end
                        OP_SUB:  o_next.acc  = i_state.acc - source;
                        OP_NOP:  o_next.acc  = i_state.acc;
                        OP_STOP: o_next.halt = 1'b1;
                        default: o_next.acc  = i_state.acc;
                    endcase
                end
            end
            CMD_READ: begin
                read_value = i_read_word;
            end
            CMD_RESTART: begin
                o_next = '0;
            end
            default: o_next = i_state;
        endcase
    end

    always_comb begin
        o_result.executed_opcode = done_opcode;
        o_result.halted          = o_next.halt;
        o_result.accumulator     = o_next.acc;
        o_result.program_counter = o_next.pc;
        o_result.read_data       = read_value;
    end

endmodule

>>> design/tiny_accumulator_cpu_step.sv
// Top level of the accumulator machine: input register, execute pass, result register.
//
// Accepts one command word per clock while results are taken, and returns one
// result word per command. A word sits in the input register while the execute
// logic reads the 16-word memory, program counter and accumulator, and the result
// lands in the output register at the same edge that commits the new machine
// state. Sustained rate is one word per cycle without output stalls, set by the
// single execute pass and the one memory write port; an instruction may read
// memory at the program counter and at its operand in that same pass. Reset
// clears the memory, program counter, accumulator and halt flag.
module tiny_accumulator_cpu_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // address[3:0], write_data[11:4], zero[15:12]
    input  logic [1:0]  i_s_axis_tuser,  // command[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // read_data[7:0], program_counter[11:8], accumulator[19:12], halted[20],
    // executed_opcode[23:21]
    output logic [23:0] o_m_axis_tdata
);
    import tacs_pkg::*;

`include "tiny_accumulator_cpu_step_macros.svh"

    logic              r_in_valid;
    t_item             r_in;
    t_state            r_state;
    logic              r_out_valid;
    t_result           r_out;

    t_state            n_state;
    t_result           n_result;
    t_wr               wr;
    t_wr               wr_raw;
    logic [ADDR_W-1:0] operand_addr;
    logic [DATA_W-1:0] fetch_word;
    logic [DATA_W-1:0] operand_word;
    logic [DATA_W-1:0] read_word;
    logic              advance;
    logic              in_take;

    // Move the held word through execute when the result register can take it.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    tacs_regfile u_regfile (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr           (wr),
        .i_fetch_addr   (r_state.pc),
        .i_operand_addr (operand_addr),
        .i_read_addr    (r_in.address),
        .o_fetch_word   (fetch_word),
        .o_operand_word (operand_word),
        .o_read_word    (read_word)
    );

    tacs_exec u_exec (
        .i_item         (r_in),
        .i_state        (r_state),
        .i_fetch_word   (fetch_word),
        .i_operand_word (operand_word),
        .i_read_word    (read_word),
        .o_operand_addr (operand_addr),
        .o_next         (n_state),
        .o_wr           (wr_raw),
        .o_result       (n_result)
    );

    // Commit the memory write only when the word actually leaves the input register.
    always_comb begin
        wr    = wr_raw;
        wr.en = wr_raw.en && advance;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_take) begin
            r_in.cmd        <= t_cmd'(i_s_axis_tuser);
            r_in.address    <= i_s_axis_tdata[ADDR_W-1:0];
            r_in.write_data <= i_s_axis_tdata[ADDR_W +: DATA_W];
        end
        if (advance) begin
            r_out <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.executed_opcode, r_out.halted, r_out.accumulator,
                              r_out.program_counter, r_out.read_data};

    `TACS_ASSERT_NOW(a_ready_when_out_empty, i_clk, i_rst_n, !r_out_valid, o_s_axis_tready)
    `TACS_ASSERT_NEXT(a_halt_holds_pc, i_clk, i_rst_n, advance && r_state.halt && r_in.cmd == CMD_EXEC, r_state.pc == $past(r_state.pc) && r_out.executed_opcode == '0)
    `TACS_ASSERT_NEXT(a_read_data_only_on_read, i_clk, i_rst_n, advance && r_in.cmd != CMD_READ, r_out.read_data == '0)
    `TACS_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, advance && r_in.cmd == CMD_RESTART, r_state == '0)

endmodule

>>> tb/tb_tiny_accumulator_cpu_step.sv
// Self-checking testbench for the accumulator machine: programs, steps and checks every result word.
module tb_tiny_accumulator_cpu_step;
    timeunit 1ns;
    timeprecision 1ps;

    import tacs_pkg::*;

    localparam int  ITEM_TARGET  = 1650;
    localparam int  CYCLE_LIMIT  = 250000;
    localparam int  RX_HOLD_LEN  = 300;
    localparam int  MAX_GAP      = 13;
    localparam logic MODE_IMM    = 1'b1;
    localparam logic MODE_ABS    = 1'b0;

    // Mirror of the machine state; predicts one result word per accepted command word.
    class acc_machine_scoreboard;
        logic [DATA_W-1:0] mem [MEM_WORDS];
        logic [ADDR_W-1:0] pc;
        logic [DATA_W-1:0] acc;
        logic              halt;
        t_result           expected_q[$];
        int                errors;
        int                checked;
        int                halted_execs;
        int                op_count [8];

        function new();
            foreach (mem[i]) mem[i] = '0;
            pc = '0;
            acc = '0;
            halt = 1'b0;
            errors = 0;
            checked = 0;
            halted_execs = 0;
            foreach (op_count[i]) op_count[i] = 0;
        endfunction

        function void note_command(t_cmd cmd, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
            t_result           r;
            logic [DATA_W-1:0] instr;
            logic [DATA_W-1:0] src;
            logic [ADDR_W-1:0] operand;
            t_opcode           opc;
            r = '0;
            case (cmd)
                CMD_LOAD: begin
                    mem[addr] = data;
                end
                CMD_EXEC: begin
                    if (!halt) begin
                        instr   = mem[pc];
                        opc     = t_opcode'(instr[OPC_LSB +: OPC_W]);
                        operand = instr[ADDR_W-1:0];
                        // advance past the fetched word before it executes
                        pc      = pc + ADDR_W'(1);
                        src     = instr[MODE_POS] ? {{(DATA_W-ADDR_W){1'b0}}, operand}
                                                  : mem[operand];
                        case (opc)
                            OP_LDA:  acc = src;
                            OP_STA:  mem[operand] = acc;
                            OP_ADD:  acc = acc + src;
                            OP_BRA:  pc = operand;
                            OP_BEQ:  if (acc == '0) pc = operand;
                            OP_SUB:  acc = acc - src;
                            OP_STOP: halt = 1'b1;
                            default: ;
                        endcase
                        r.executed_opcode = opc;
                        op_count[opc]++;
                    end else begin
                        halted_execs++;
                    end
                end
                CMD_READ: begin
                    r.read_data = mem[addr];
                end
                default: begin
                    pc = '0;
                    acc = '0;
                    halt = 1'b0;
                end
            endcase
            r.program_counter = pc;
            r.accumulator     = acc;
            r.halted          = halt;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $error("result word with no command outstanding: %h", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.read_data !== want.read_data) begin
                $error("read_data: expected %0d, got %0d", want.read_data, got.read_data);
                errors++;
            end
            if (got.program_counter !== want.program_counter) begin
                $error("program_counter: expected %0d, got %0d",
                       want.program_counter, got.program_counter);
                errors++;
            end
            if (got.accumulator !== want.accumulator) begin
                $error("accumulator: expected %0d, got %0d", want.accumulator, got.accumulator);
                errors++;
            end
            if (got.halted !== want.halted) begin
                $error("halted: expected %0d, got %0d", want.halted, got.halted);
                errors++;
            end
            if (got.executed_opcode !== want.executed_opcode) begin
                $error("executed_opcode: expected %0d, got %0d",
                       want.executed_opcode, got.executed_opcode);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata;   // address[3:0], write_data[11:4], zero[15:12]
    logic [1:0]  i_s_axis_tuser;   // command[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // read_data[7:0], program_counter[11:8], accumulator[19:12], halted[20],
    // executed_opcode[23:21]
    logic [23:0] o_m_axis_tdata;

    acc_machine_scoreboard sb;
    int   sent_count;
    int   cycle_count;
    int   rx_holds;
    logic tx_quiet;
    logic rx_quiet;
    logic rx_hold_req;

    tiny_accumulator_cpu_step dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_result(t_result'(o_m_axis_tdata));
        end
    end

    function automatic logic [DATA_W-1:0] make_instr(t_opcode opc, logic mode,
                                                     logic [ADDR_W-1:0] operand);
        return {opc, mode, operand};
    endfunction

    function automatic logic [DATA_W-1:0] random_instr();
        int      pick;
        t_opcode opc;
        // keep STOP rare so programs run for a while
        pick = $urandom_range(0, 15);
        opc  = (pick < 14) ? t_opcode'(pick % 7) : OP_STOP;
        return make_instr(opc, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    endfunction

    task automatic send_command(t_cmd cmd, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap != 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = cmd;
        i_s_axis_tdata  = {4'b0000, data, addr};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_command(cmd, addr, data);
        sent_count++;
    endtask

    // Drop valid and hold until every outstanding result word has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_program();
        int base;
        int n;
        int steps;
        int pick;
        base = $urandom_range(0, 15);
        n    = $urandom_range(3, 16);
        for (int i = 0; i < n; i++) begin
            send_command(CMD_LOAD, 4'(base + i),
                         ($urandom_range(0, 3) == 0) ? 8'($urandom) : random_instr());
        end
        if ($urandom_range(0, 3) != 0) send_command(CMD_RESTART, 4'($urandom), 8'($urandom));
        steps = $urandom_range(4, 24);
        for (int i = 0; i < steps; i++) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                send_command(CMD_LOAD, 4'($urandom), random_instr());
            end else if (pick < 3) begin
                send_command(CMD_READ, 4'($urandom), 8'($urandom));
            end else begin
                send_command(CMD_EXEC, 4'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic send_noise(int n);
        for (int i = 0; i < n; i++) begin
            send_command(t_cmd'($urandom_range(0, 3)), 4'($urandom), 8'($urandom));
        end
    endtask

    // Receiver: random stall per word, plus a long hold on request.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_m_axis_tready = 1'b0;
                rx_holds++;
                repeat (RX_HOLD_LEN) @(negedge i_clk);
            end
            gap = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                i_m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    initial begin
        int episode;
        int kind;
        sb = new();
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = CMD_LOAD;
        i_m_axis_tready = 1'b0;
        tx_quiet        = 1'b0;
        rx_quiet        = 1'b0;
        rx_hold_req     = 1'b0;
        sent_count      = 0;
        rx_holds        = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed program: both modes, 8-bit wrap both ways, mode bit ignored on
        // store and branch, taken and untaken BEQ, STOP with pc wrap, then halted.
        send_command(CMD_LOAD, 4'd14, 8'hFE);
        send_command(CMD_LOAD, 4'd0,  make_instr(OP_LDA,  MODE_IMM, 4'd5));
        send_command(CMD_LOAD, 4'd1,  make_instr(OP_ADD,  MODE_ABS, 4'd14));
        send_command(CMD_LOAD, 4'd2,  make_instr(OP_SUB,  MODE_IMM, 4'd4));
        send_command(CMD_LOAD, 4'd3,  make_instr(OP_STA,  MODE_IMM, 4'd13));
        send_command(CMD_LOAD, 4'd4,  make_instr(OP_NOP,  MODE_ABS, 4'd0));
        send_command(CMD_LOAD, 4'd5,  make_instr(OP_SUB,  MODE_ABS, 4'd13));
        send_command(CMD_LOAD, 4'd6,  make_instr(OP_BEQ,  MODE_IMM, 4'd9));
        send_command(CMD_LOAD, 4'd9,  make_instr(OP_ADD,  MODE_IMM, 4'd1));
        send_command(CMD_LOAD, 4'd10, make_instr(OP_BEQ,  MODE_ABS, 4'd0));
        send_command(CMD_LOAD, 4'd11, make_instr(OP_BRA,  MODE_ABS, 4'd15));
        send_command(CMD_LOAD, 4'd15, make_instr(OP_STOP, MODE_ABS, 4'd0));
        repeat (11) send_command(CMD_EXEC, 4'd0, 8'h00);
        send_command(CMD_EXEC, 4'hF, 8'hFF);
        send_command(CMD_READ, 4'd13, 8'h00);
        send_command(CMD_LOAD, 4'd7, 8'hFF);
        send_command(CMD_RESTART, 4'hF, 8'hFF);
        drain_results();

        episode = 0;
        while (sent_count < ITEM_TARGET) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            kind = (episode == 0) ? 8 : (episode == 1) ? 9 : $urandom_range(0, 9);
            case (kind)
                7: send_noise($urandom_range(5, 15));
                8: begin
                    // fill the block while the receiver holds off
                    tx_quiet    = 1'b1;
                    rx_hold_req = 1'b1;
                    send_noise(40);
                end
                9: begin
                    drain_results();
                    run_program();
                end
                default: run_program();
            endcase
            episode++;
        end

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected result words never arrived", sb.pending());
            sb.errors++;
        end

        $display("Sent %0d commands in %0d cycles, checked %0d results, %0d long output holds.",
                 sent_count, cycle_count, sb.checked, rx_holds);
        $display("Executed LDA %0d STA %0d ADD %0d BRA %0d BEQ %0d SUB %0d NOP %0d STOP %0d, %0d while halted.",
                 sb.op_count[OP_LDA], sb.op_count[OP_STA], sb.op_count[OP_ADD],
                 sb.op_count[OP_BRA], sb.op_count[OP_BEQ], sb.op_count[OP_SUB],
                 sb.op_count[OP_NOP], sb.op_count[OP_STOP], sb.halted_execs);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
